>>> rtl/core/mvm_pkg.sv
// Package for the matrix-vector multiply block: shared constants, codes and
// the control word passed between the sequencer and the MAC datapath.
// No dependencies.
package mvm_pkg;

  // Default sizes, overridable by top-level parameters
  localparam int unsigned MAX_COLUMNS_DEF   = 256;
  localparam int unsigned MAX_ROWS_DEF      = 256;
  localparam int unsigned ELEMENT_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int unsigned CFG_W      = 9;   // count registers
  localparam int unsigned CFG_IDX_W  = 1;   // register index
  localparam int unsigned ACC_W      = 40;  // accumulator
  localparam int unsigned RES_W      = 32;  // row result
  localparam int unsigned ROW_NUM_W  = 8;   // row number on the result

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  // Input commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_MATRIX = 1'b1;

  // Control word that travels with a matrix element down the pipeline
  typedef struct packed {
    logic                 vld;
    logic                 end_row;
    logic                 last_row;
    logic [ROW_NUM_W-1:0] row_num;
  } ctrl_t;

endpackage

>>> rtl/core/mvm_if.sv
// Valid/ready channel interfaces for the matrix-vector multiply block.
// Depends on mvm_pkg.
interface mvm_in_if
  import mvm_pkg::*;
#(
  parameter int unsigned ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [ELEMENT_WIDTH-1:0] operand_value;

  modport source (output valid, command, operand_value, input ready);
  modport sink   (input valid, command, operand_value, output ready);
endinterface

interface mvm_out_if
  import mvm_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [RES_W-1:0]     row_result;
  logic [ROW_NUM_W-1:0] row_number;
  logic                 last_row;

  modport source (output valid, row_result, row_number, last_row, input ready);
  modport sink   (input valid, row_result, row_number, last_row, output ready);
endinterface

>>> rtl/core/mvm_vec_store.sv
// Vector element store: one write port, one registered read port.
// Depends on nothing but its parameters.
module mvm_vec_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered, held while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/mvm_seq.sv
// Sequencer: count registers, load/column/row positions, store addressing
// and the first pipeline stage. Depends on mvm_pkg.
module mvm_seq
  import mvm_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS   = MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS      = MAX_ROWS_DEF,
  parameter int unsigned ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
  localparam int unsigned CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int unsigned RPW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  logic                     adv_i,
  input  logic                     in_valid_i,
  input  logic                     in_cmd_i,
  input  logic [ELEMENT_WIDTH-1:0] in_op_i,
  output logic                     mem_we_o,
  output logic [CIW-1:0]           mem_waddr_o,
  output logic [CIW-1:0]           mem_raddr_o,
  output logic [ELEMENT_WIDTH-1:0] op_s1_o,
  output ctrl_t                    ctrl_s1_o
);

  logic [CIW-1:0]           cols_m1_q, load_pos_q, col_pos_q;
  logic [RPW-1:0]           rows_m1_q, row_pos_q;
  logic [ELEMENT_WIDTH-1:0] op_s1_q;
  ctrl_t                    ctrl_s1_q, ctrl_s1_d;
  logic                     xfer, is_mat, end_row, last_row;
  logic [31:0]              wr32, cols_eff, rows_eff, row32;

  assign xfer     = in_valid_i & adv_i;
  assign is_mat   = (in_cmd_i == CMD_MATRIX);
  assign end_row  = (col_pos_q == cols_m1_q);
  assign last_row = (row_pos_q == rows_m1_q);
  assign row32    = 32'(row_pos_q);

  // Effective counts: zero acts as one, too large clamps to the maximum
  always_comb begin
    wr32 = 32'(cfg_wdata_i);
    if (wr32 == 32'd0) begin
      cols_eff = 32'd1;
      rows_eff = 32'd1;
    end else begin
      cols_eff = (wr32 > 32'(MAX_COLUMNS)) ? 32'(MAX_COLUMNS) : wr32;
      rows_eff = (wr32 > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : wr32;
    end
  end

  // Control word for the element entering the pipeline
  always_comb begin
    ctrl_s1_d.vld      = xfer & is_mat;
    ctrl_s1_d.end_row  = end_row;
    ctrl_s1_d.last_row = last_row;
    ctrl_s1_d.row_num  = row32[ROW_NUM_W-1:0];
  end

  // Count registers and positions; a register write restarts the pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_m1_q  <= '0;
      rows_m1_q  <= '0;
      load_pos_q <= '0;
      col_pos_q  <= '0;
      row_pos_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_ROW_COUNT) begin
        rows_m1_q <= RPW'(rows_eff - 32'd1);
      end else begin
        cols_m1_q <= CIW'(cols_eff - 32'd1);
      end
      load_pos_q <= '0;
      col_pos_q  <= '0;
      row_pos_q  <= '0;
    end else if (xfer) begin
      if (!is_mat) begin
        load_pos_q <= (load_pos_q == cols_m1_q) ? '0 : load_pos_q + CIW'(1);
      end else begin
        col_pos_q <= end_row ? '0 : col_pos_q + CIW'(1);
        if (end_row) begin
          row_pos_q <= last_row ? '0 : row_pos_q + RPW'(1);
        end
      end
    end
  end

  // Stage 1 control, in step with the store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_s1_q <= '0;
    end else if (adv_i) begin
      ctrl_s1_q <= ctrl_s1_d;
    end
  end

  // Stage 1 operand
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op_s1_q <= in_op_i;
    end
  end

  assign mem_we_o    = xfer & ~is_mat;
  assign mem_waddr_o = load_pos_q;
  assign mem_raddr_o = col_pos_q;
  assign op_s1_o     = op_s1_q;
  assign ctrl_s1_o   = ctrl_s1_q;

endmodule

>>> rtl/core/mvm_mac.sv
// MAC datapath: product stage, saturating accumulator and result register.
// Depends on mvm_pkg.
module mvm_mac
  import mvm_pkg::*;
#(
  parameter int unsigned ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     restart_i,
  input  logic [ELEMENT_WIDTH-1:0] op_s1_i,
  input  logic [ELEMENT_WIDTH-1:0] vec_s1_i,
  input  ctrl_t                    ctrl_s1_i,
  input  logic                     out_ready_i,
  output logic                     adv_o,
  output logic                     out_valid_o,
  output logic [RES_W-1:0]         row_result_o,
  output logic [ROW_NUM_W-1:0]     row_number_o,
  output logic                     last_row_o
);

  localparam int unsigned PW = 2 * ELEMENT_WIDTH;
  localparam int unsigned SW = ((PW > ACC_W) ? PW : ACC_W) + 1;
  localparam logic signed [SW-1:0] AccMax = SW'((65'sd1 <<< (ACC_W - 1)) - 65'sd1);
  localparam logic signed [SW-1:0] AccMin = -AccMax - SW'(1);
  localparam logic signed [ACC_W-1:0] ResMax = 40'sh007FFFFFFF;
  localparam logic signed [ACC_W-1:0] ResMin = 40'shFF80000000;

  logic signed [PW-1:0]    prod_q;
  ctrl_t                   ctrl_s2_q;
  logic signed [ACC_W-1:0] acc_q, acc_sat, res_sat;
  logic signed [SW-1:0]    sum;
  logic                    adv, out_valid_q;
  logic [RES_W-1:0]        row_result_q;
  logic [ROW_NUM_W-1:0]    row_number_q;
  logic                    last_row_q;

  // Whole pipeline moves unless a result is held untaken
  assign adv = ~out_valid_q | out_ready_i;

  // Stage 2: product
  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= $signed(op_s1_i) * $signed(vec_s1_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_s2_q <= '0;
    end else if (adv) begin
      ctrl_s2_q <= ctrl_s1_i;
    end
  end

  // Accumulate with 40-bit saturation, then clamp to the 32-bit result
  always_comb begin
    sum     = SW'(acc_q) + SW'(prod_q);
    if (sum > AccMax) begin
      acc_sat = ACC_W'(AccMax);
    end else if (sum < AccMin) begin
      acc_sat = ACC_W'(AccMin);
    end else begin
      acc_sat = ACC_W'(sum);
    end
    if (acc_sat > ResMax) begin
      res_sat = ResMax;
    end else if (acc_sat < ResMin) begin
      res_sat = ResMin;
    end else begin
      res_sat = acc_sat;
    end
  end

  // Stage 3: accumulator, cleared at row end and on restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (restart_i) begin
      acc_q <= '0;
    end else if (adv && ctrl_s2_q.vld) begin
      acc_q <= ctrl_s2_q.end_row ? '0 : acc_sat;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ctrl_s2_q.vld & ctrl_s2_q.end_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && ctrl_s2_q.vld && ctrl_s2_q.end_row) begin
      row_result_q <= RES_W'(res_sat);
      row_number_q <= ctrl_s2_q.row_num;
      last_row_q   <= ctrl_s2_q.last_row;
    end
  end

  assign adv_o        = adv;
  assign out_valid_o  = out_valid_q;
  assign row_result_o = row_result_q;
  assign row_number_o = row_number_q;
  assign last_row_o   = last_row_q;

endmodule

>>> rtl/core/matrix_vector_multiply.sv
// Matrix-vector multiply y = M*v, top level: vector store, sequencer, MAC.
// Depends on mvm_pkg, mvm_if, mvm_vec_store, mvm_seq, mvm_mac.
//
//   channel  dir  handshake        payload
//   in_i     in   valid/ready      command, operand_value (Q8.8)
//   out_o    out  valid/ready      row_result (Q16.16), row_number, last_row
//   cfg      in   cfg_we_i only    cfg_idx_i, cfg_wdata_i
//
// One item per cycle unless a result is held: a vector load writes the store, a
// matrix element reads it and goes through a multiply stage and the accumulator stage.
// A row's result is registered after stage 1 and the multiply stage.
// Reset clears positions and the accumulator; the store holds no data until
// loaded and needs no clearing pass. While a result waits untaken the whole
// pipeline, including in_i.ready, is held.
module matrix_vector_multiply
  import mvm_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS   = MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS      = MAX_ROWS_DEF,
  parameter int unsigned ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  mvm_in_if.sink               in_i,
  mvm_out_if.source            out_o
);

  localparam int unsigned CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic                     adv, mem_we;
  logic [CIW-1:0]           mem_waddr, mem_raddr;
  logic [ELEMENT_WIDTH-1:0] op_s1, vec_s1;
  ctrl_t                    ctrl_s1;

  mvm_seq #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_ROWS      (MAX_ROWS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (adv),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.command),
    .in_op_i     (in_i.operand_value),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_raddr_o (mem_raddr),
    .op_s1_o     (op_s1),
    .ctrl_s1_o   (ctrl_s1)
  );

  mvm_vec_store #(
    .DEPTH (MAX_COLUMNS),
    .WIDTH (ELEMENT_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_i.operand_value),
    .re_i    (adv),
    .raddr_i (mem_raddr),
    .rdata_o (vec_s1)
  );

  mvm_mac #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (cfg_we_i),
    .op_s1_i      (op_s1),
    .vec_s1_i     (vec_s1),
    .ctrl_s1_i    (ctrl_s1),
    .out_ready_i  (out_o.ready),
    .adv_o        (adv),
    .out_valid_o  (out_o.valid),
    .row_result_o (out_o.row_result),
    .row_number_o (out_o.row_number),
    .last_row_o   (out_o.last_row)
  );

  assign in_i.ready = adv;

`ifndef SYNTH
  // A held result back-pressures the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while a result is stalled");

  // Only matrix transfers enter the MAC pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (ctrl_s1.vld == $past(in_i.command == CMD_MATRIX)))
    else $error("stage 1 valid does not follow the transferred command");

  // Nothing enters stage 1 without an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !in_i.valid) |=> !ctrl_s1.vld)
    else $error("stage 1 valid without a transfer");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for matrix_vector_multiply: directed table, then random
// load/matrix passes under random source gaps and sink stalls, with a built-in GEMV predictor.
// Depends on mvm_pkg, mvm_if and the matrix_vector_multiply RTL.
module testbench;
  import mvm_pkg::*;

  localparam int unsigned ITEM_TARGET    = 450;
  localparam int unsigned DRAIN_CYCLES   = 8;     // margin beyond the result pipeline
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DIR_LEN        = 30;

  localparam longint ACC_HI = 64'sd549755813887;  // 2^39 - 1
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint RES_HI = 64'sd2147483647;
  localparam longint RES_LO = -RES_HI - 1;

  typedef struct packed {
    logic [RES_W-1:0]     value;
    logic [ROW_NUM_W-1:0] rnum;
    logic                 last;
  } row_res_t;

  typedef enum logic {STEP_ITEM, STEP_REG} step_kind_e;

  typedef struct packed {
    step_kind_e           kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 cmd;
    logic [15:0]          data;
    logic                 typed;
    row_res_t             res;
  } dir_step_t;

  localparam row_res_t NO_ROW = '0;

  // Directed table: extremes, saturation both ways, count corner cases,
  // excess loads, wrap after the final row and restart in the middle of a row
  localparam dir_step_t DIRECTED [DIR_LEN] = '{
    '{STEP_ITEM, REG_ROW_COUNT, CMD_LOAD,   16'h0100, 1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_MATRIX, 16'h0100, 1'b1, '{32'h0001_0000, 8'd0, 1'b1}},
    '{STEP_REG,  REG_COL_COUNT, CMD_LOAD,   16'd3,    1'b0, NO_ROW},
    '{STEP_REG,  REG_ROW_COUNT, CMD_LOAD,   16'd2,    1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_LOAD,   16'h8000, 1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_LOAD,   16'h8000, 1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_LOAD,   16'h8000, 1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_MATRIX, 16'h8000, 1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_MATRIX, 16'h8000, 1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_MATRIX, 16'h8000, 1'b1, '{32'h7FFF_FFFF, 8'd0, 1'b0}},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_MATRIX, 16'h7FFF, 1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_MATRIX, 16'h7FFF, 1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_MATRIX, 16'h7FFF, 1'b1, '{32'h8000_0000, 8'd1, 1'b1}},
    '{STEP_REG,  REG_COL_COUNT, CMD_LOAD,   16'd0,    1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_LOAD,   16'h7FFF, 1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_MATRIX, 16'h7FFF, 1'b1, '{32'h3FFF_0001, 8'd0, 1'b0}},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_MATRIX, 16'hFFFF, 1'b1, '{32'hFFFF_8001, 8'd1, 1'b1}},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_MATRIX, 16'h0000, 1'b1, '{32'h0000_0000, 8'd0, 1'b0}},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_MATRIX, 16'h5555, 1'b0, NO_ROW},
    '{STEP_REG,  REG_ROW_COUNT, CMD_LOAD,   16'd0,    1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_LOAD,   16'h0002, 1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_LOAD,   16'h0003, 1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_MATRIX, 16'h0001, 1'b1, '{32'h0000_0003, 8'd0, 1'b1}},
    '{STEP_REG,  REG_COL_COUNT, CMD_LOAD,   16'd2,    1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_LOAD,   16'h1234, 1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_LOAD,   16'hEDCC, 1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_MATRIX, 16'h4000, 1'b0, NO_ROW},
    '{STEP_REG,  REG_ROW_COUNT, CMD_LOAD,   16'd1,    1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_MATRIX, 16'h0100, 1'b0, NO_ROW},
    '{STEP_ITEM, REG_ROW_COUNT, CMD_MATRIX, 16'h0100, 1'b0, NO_ROW}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  mvm_in_if #(.ELEMENT_WIDTH(ELEMENT_WIDTH_DEF)) in_ch ();
  mvm_out_if out_ch ();

  matrix_vector_multiply dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  logic [15:0]      vec_mem    [MAX_COLUMNS_DEF];
  bit               vec_loaded [MAX_COLUMNS_DEF];
  longint           acc_q16;
  int unsigned      col_pos, row_pos, load_pos;
  logic [CFG_W-1:0] row_reg, col_reg;

  row_res_t    pending_rows [$];
  int unsigned err_count    = 0;
  int unsigned items_sent   = 0;
  int unsigned src_burst    = 0;
  int unsigned snk_burst    = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned eff_count(logic [CFG_W-1:0] raw, int unsigned limit);
    if (raw == '0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // Wait drawn per transfer; occasional bursts with no idling at all
  function automatic int unsigned draw_wait(inout int unsigned burst_left);
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(8, 40);
    return $urandom_range(0, 17);
  endfunction

  // Element values biased toward the extremes so saturation gets hit
  function automatic logic [15:0] pick_element();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // GEMV predictor: one input transfer, at most one row result
  task automatic step_gemv(input logic cmd, input logic [15:0] operand,
                           output bit produced, output row_res_t row);
    int unsigned cols, rows;
    longint      prod, clipped;
    cols     = eff_count(col_reg, MAX_COLUMNS_DEF);
    rows     = eff_count(row_reg, MAX_ROWS_DEF);
    produced = 1'b0;
    row      = '0;
    if (cmd == CMD_LOAD) begin
      if (load_pos >= cols) load_pos = 0;
      vec_mem[load_pos]    = operand;
      vec_loaded[load_pos] = 1'b1;
      load_pos++;
      if (load_pos >= cols) load_pos = 0;
    end else begin
      if (col_pos >= cols) col_pos = 0;
      if (row_pos >= rows) row_pos = 0;
      prod    = longint'($signed(operand)) * longint'($signed(vec_mem[col_pos]));
      acc_q16 = clamp(acc_q16 + prod, ACC_LO, ACC_HI);
      col_pos++;
      if (col_pos >= cols) begin
        clipped   = clamp(acc_q16, RES_LO, RES_HI);
        row.value = clipped[RES_W-1:0];
        row.rnum  = row_pos[ROW_NUM_W-1:0];
        row.last  = (row_pos + 1 >= rows);
        produced  = 1'b1;
        acc_q16   = 0;
        col_pos   = 0;
        row_pos   = row.last ? 0 : row_pos + 1;
      end
    end
  endtask

  // Register write, only with the pipeline drained; restarts the pass
  task automatic write_count_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROW_COUNT: row_reg = value;
      REG_COL_COUNT: col_reg = value;
      default: ;
    endcase
    acc_q16  = 0;
    col_pos  = 0;
    row_pos  = 0;
    load_pos = 0;
  endtask

  // One input transfer; called and returns at a falling edge
  task automatic transfer_item(input logic cmd, input logic [15:0] operand,
                               input bit typed, input row_res_t typed_row);
    int unsigned gap;
    bit          produced;
    row_res_t    row;
    gap = draw_wait(src_burst);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.operand_value <= operand;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
    step_gemv(cmd, operand, produced, row);
    if (typed) pending_rows.push_back(typed_row);
    else if (produced) pending_rows.push_back(row);
  endtask

  // Stimulus
  initial begin : stimulus
    int unsigned      phase, eff_r, eff_c;
    int unsigned      n_rows, n_loads, n_mat;
    bit               big;
    logic [CFG_W-1:0] row_raw, col_raw;
    in_ch.valid         = 1'b0;
    in_ch.command       = CMD_LOAD;
    in_ch.operand_value = '0;
    cfg_we              = 1'b0;
    cfg_idx             = REG_ROW_COUNT;
    cfg_wdata           = '0;
    row_reg             = 9'd1;
    col_reg             = 9'd1;
    acc_q16             = 0;
    col_pos             = 0;
    row_pos             = 0;
    load_pos            = 0;
    foreach (vec_loaded[i]) vec_loaded[i] = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_LEN; i++) begin
      if (DIRECTED[i].kind == STEP_REG)
        write_count_reg(DIRECTED[i].reg_idx, DIRECTED[i].data[CFG_W-1:0]);
      else
        transfer_item(DIRECTED[i].cmd, DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].res);
    end

    // Random passes: mostly well-formed load-then-stream sequences with small
    // sizes, plus short/excess loads, stray loads and cut-off rows; one pass
    // at the largest row count
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      big = (phase == 3);
      if (phase == 3) begin
        row_raw = 9'd511;
        col_raw = 9'd1;
      end else begin
        case ($urandom_range(0, 9))
          0: row_raw = '0;
          1: row_raw = 9'd256;
          2: row_raw = 9'($urandom_range(257, 511));
          default: row_raw = 9'($urandom_range(1, 6));
        endcase
        col_raw = ($urandom_range(0, 9) == 0) ? '0 : 9'($urandom_range(1, 8));
      end
      if ($urandom_range(0, 1) == 1) begin
        write_count_reg(REG_ROW_COUNT, row_raw);
        write_count_reg(REG_COL_COUNT, col_raw);
      end else begin
        write_count_reg(REG_COL_COUNT, col_raw);
        write_count_reg(REG_ROW_COUNT, row_raw);
      end
      eff_r = eff_count(row_reg, MAX_ROWS_DEF);
      eff_c = eff_count(col_reg, MAX_COLUMNS_DEF);

      if (phase == 3) n_rows = eff_r + 1;  // walks into the wrap after the final row
      else if ($urandom_range(0, 2) == 0) n_rows = eff_r + $urandom_range(0, 1);
      else n_rows = $urandom_range(1, (eff_r < 4) ? eff_r : 4);
      if (!big && n_rows > 8) n_rows = $urandom_range(1, 8);

      n_loads = eff_c;
      if (!big && $urandom_range(0, 4) == 0) n_loads = $urandom_range(0, eff_c + 3);
      n_mat = n_rows * eff_c;
      if (!big && $urandom_range(0, 4) == 0) n_mat += $urandom_range(1, eff_c);

      repeat (n_loads) transfer_item(CMD_LOAD, pick_element(), 1'b0, NO_ROW);
      repeat (n_mat) begin
        if (!big && $urandom_range(0, 11) == 0)
          transfer_item(CMD_LOAD, pick_element(), 1'b0, NO_ROW);
        // never read a store entry that has not been written yet
        if (!vec_loaded[col_pos])
          transfer_item(CMD_LOAD, pick_element(), 1'b0, NO_ROW);
        else
          transfer_item(CMD_MATRIX, pick_element(), 1'b0, NO_ROW);
      end
      phase++;
    end

    in_ch.valid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result side: random stalls, each transfer checked against the oldest row
  initial begin : result_sink
    int unsigned stall;
    row_res_t    want;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = draw_wait(snk_burst);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_rows.size() == 0) begin
        err_count++;
        $display("%0t: unexpected row result: expected none, got %h row %0d last %0b",
                 $time, out_ch.row_result, out_ch.row_number, out_ch.last_row);
      end else begin
        want = pending_rows.pop_front();
        if (out_ch.row_result !== want.value) begin
          err_count++;
          $display("%0t: row_result mismatch: expected %h, got %h",
                   $time, want.value, out_ch.row_result);
        end
        if (out_ch.row_number !== want.rnum) begin
          err_count++;
          $display("%0t: row_number mismatch: expected %0d, got %0d",
                   $time, want.rnum, out_ch.row_number);
        end
        if (out_ch.last_row !== want.last) begin
          err_count++;
          $display("%0t: last_row mismatch: expected %0b, got %0b",
                   $time, want.last, out_ch.last_row);
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
